/* sv/ppamt_pkg.sv */
`default_nettype none
package ppamt_pkg;
    localparam int TableDepthDefault = 16;
    localparam logic [31:0] AckTimeoutReset = 32'd15000;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_MATCH  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_POST_ID   = 3'd1;
    localparam logic [2:0] ST_PART_NO_SEQ  = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_DUP_COMPLETE = 3'd4;
    localparam logic [2:0] ST_DUP_PART     = 3'd5;
    localparam logic [2:0] ST_NONE         = 3'd6;

    typedef struct packed {
        logic [31:0] stream;
        logic [31:0] post_id;
        logic [31:0] seq;
        logic        complete;
        logic        seq_flag;
        logic [31:0] expiry;
    } entry_t;
endpackage
`default_nettype wire

/* sv/ppamt_entry_mem.sv */
`default_nettype none
module ppamt_entry_mem
    import ppamt_pkg::*;
#(
    parameter int DEPTH = TableDepthDefault,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);
    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* sv/ppamt_free_fifo.sv */
`default_nettype none
module ppamt_free_fifo
    import ppamt_pkg::*;
#(
    parameter int DEPTH = TableDepthDefault,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop,
    input  wire logic          push,
    input  wire logic [AW-1:0] push_slot,
    output logic    [AW-1:0]   head_slot,
    output logic    [AW:0]     count
);
    // list is initialized as identity; a written bit marks entries overwritten since reset
    logic [AW-1:0] list [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [AW-1:0] head_reg;
    logic [AW:0]   count_reg;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic [AW-1:0] head_next;

    assign head_slot = written_reg[head_reg] ? list[head_reg] : head_reg;
    assign count = count_reg;
    assign head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, head_next} + count_reg - 1'b1;
    // tail after the pop when both happen (rotate), otherwise after head
    logic [AW:0] base_sum;
    assign base_sum = pop ? tail_sum : ({1'b0, head_reg} + count_reg);
    assign tail = (base_sum >= (AW+1)'(DEPTH)) ? AW'(base_sum - (AW+1)'(DEPTH)) : base_sum[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            list[tail] <= push_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            head_reg    <= '0;
            count_reg   <= (AW+1)'(DEPTH);
        end
        else
        begin
            if (push)
            begin
                written_reg[tail] <= 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_next;
            end
            count_reg <= count_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) (push && !pop) |-> (count_reg < (AW+1)'(DEPTH));
    endproperty
    assert property (p_no_overflow) else $error("free list overflow");
    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) (pop && !push) |-> (count_reg != '0);
    endproperty
    assert property (p_no_underflow) else $error("free list underflow");
    property p_count_range;
        @(posedge clk) disable iff (!rst_n) 1'b1 |-> (count_reg <= (AW+1)'(DEPTH));
    endproperty
    assert property (p_count_range) else $error("free count out of range");
endmodule
`default_nettype wire

/* sv/pending_post_ack_match_table_unit.sv */
// One operation at a time: start is taken when busy is low, and the result
// appears on the result ports for exactly one cycle with done high. Add and
// match scan every entry of the table memory, one read per cycle; remove
// reads only its own slot, and a rejected add or an unused operation code
// goes straight to the result.
// The result cannot be held off and must be captured in its strobe cycle.
// ack_timeout_ms is written through cfg_valid/cfg_ready while idle.
`default_nettype none
module pending_post_ack_match_table_unit
    import ppamt_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault,
    localparam int AW = $clog2(TABLE_DEPTH)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic signed [31:0] stream_id,
    input  wire logic [31:0] msg_id,
    input  wire logic [31:0] seq_num,
    input  wire logic        has_post_id,
    input  wire logic        has_seq,
    input  wire logic        is_complete,
    input  wire logic [3:0]  slot_in,
    input  wire logic [31:0] now_ms,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             done,
    output logic [2:0]       status,
    output logic [3:0]       slot_out,
    output logic [31:0]      expire_ms,
    output logic             slot_complete,
    output logic             slot_has_seq
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_RDRM = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] timeout_reg;
    logic [1:0]  op_reg;
    logic [31:0] st_reg, id_reg, seq_reg, now_reg;
    logic        hseq_reg, cmp_reg;
    logic [3:0]  slot_in_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [AW:0] rd_cnt_reg;     // address being issued
    logic [AW-1:0] cmp_idx_reg;  // index whose data is on rd_data
    logic        dupc_reg, dupp_reg, fc_reg, fa_reg;
    logic [2:0]  status_reg;
    logic [3:0]  slot_out_reg;
    logic [31:0] exp_reg;
    logic        oc_reg, os_reg, done_reg;

    entry_t      rd_data, wr_data;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic        fl_pop, fl_push;
    logic [AW-1:0] fl_push_slot, fl_head;
    logic [AW:0] fl_count;

    ppamt_entry_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    ppamt_free_fifo #(.DEPTH(TABLE_DEPTH)) u_free (
        .clk(clk), .rst_n(rst_n), .pop(fl_pop), .push(fl_push),
        .push_slot(fl_push_slot), .head_slot(fl_head), .count(fl_count)
    );

    logic accept, slot_ok;
    logic key_hit, e_valid;
    assign accept = start && !busy;
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign slot_ok = ({28'd0, slot_in_reg} < 32'(TABLE_DEPTH));
    assign e_valid = valid_reg[cmp_idx_reg];
    assign key_hit = e_valid && rd_data.stream == st_reg && rd_data.post_id == id_reg;
    // a scan starts at entry 0, a remove reads its own slot
    assign rd_addr = (state_reg == S_IDLE) ?
                     ((operation == OP_REMOVE) ? AW'(slot_in) : '0) :
                     rd_cnt_reg[AW-1:0];

    // add commit in S_LAST, remove in S_RDRM
    logic add_commit, rm_commit, add_dup;
    assign add_dup = dupc_reg || dupp_reg;
    assign add_commit = (state_reg == S_LAST) && (op_reg == OP_ADD) && !add_dup;
    assign rm_commit = (state_reg == S_RDRM) && slot_ok && valid_reg[AW'(slot_in_reg)];
    assign wr_en = add_commit;
    assign wr_addr = fl_head;
    assign wr_data = '{stream: st_reg, post_id: id_reg, seq: seq_reg, complete: cmp_reg,
                       seq_flag: hseq_reg, expiry: now_reg + timeout_reg};
    assign fl_pop = add_commit || ((state_reg == S_LAST) && (op_reg == OP_ADD) && add_dup);
    assign fl_push = ((state_reg == S_LAST) && (op_reg == OP_ADD) && add_dup) || rm_commit;
    assign fl_push_slot = rm_commit ? AW'(slot_in_reg) : fl_head;

    logic [2:0] pre_status;
    always_comb
    begin
        pre_status = ST_OK;
        if (!has_post_id)
        begin
            pre_status = ST_NO_POST_ID;
        end
        else if (!is_complete && !has_seq)
        begin
            pre_status = ST_PART_NO_SEQ;
        end
        else if (fl_count == '0)
        begin
            pre_status = ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            timeout_reg <= AckTimeoutReset;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (add_commit)
            begin
                valid_reg[fl_head] <= 1'b1;
            end
            if (rm_commit)
            begin
                valid_reg[AW'(slot_in_reg)] <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (operation == OP_REMOVE)
                        begin
                            state_reg <= S_RDRM;
                        end
                        else if ((operation == OP_MATCH) ||
                                 ((operation == OP_ADD) && pre_status == ST_OK))
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_cnt_reg == (AW+1)'(TABLE_DEPTH))
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST, S_RDRM:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= operation; st_reg <= stream_id; id_reg <= msg_id;
                seq_reg <= seq_num; now_reg <= now_ms; hseq_reg <= has_seq;
                cmp_reg <= is_complete; slot_in_reg <= slot_in;
                rd_cnt_reg <= (AW+1)'(1);
                cmp_idx_reg <= '0;
                dupc_reg <= 1'b0; dupp_reg <= 1'b0; fc_reg <= 1'b0; fa_reg <= 1'b0;
                status_reg <= (operation == OP_ADD) ? pre_status : ST_NONE;
                slot_out_reg <= '0; exp_reg <= '0; oc_reg <= 1'b0; os_reg <= 1'b0;
            end
            S_SCAN:
            begin
                // rd_data holds entry cmp_idx_reg
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
                cmp_idx_reg <= cmp_idx_reg + 1'b1;
                if (op_reg == OP_ADD)
                begin
                    if (key_hit && rd_data.complete)
                    begin
                        dupc_reg <= 1'b1;
                    end
                    if (key_hit && !cmp_reg && rd_data.seq_flag && rd_data.seq == seq_reg)
                    begin
                        dupp_reg <= 1'b1;
                    end
                end
                else if (!hseq_reg)
                begin
                    if (key_hit && !rd_data.seq_flag && !fa_reg)
                    begin
                        fa_reg <= 1'b1;
                        slot_out_reg <= 4'(cmp_idx_reg); exp_reg <= rd_data.expiry;
                        oc_reg <= rd_data.complete; os_reg <= rd_data.seq_flag;
                    end
                end
                else if (key_hit && rd_data.seq_flag && rd_data.seq == seq_reg)
                begin
                    if (rd_data.complete && !fc_reg)
                    begin
                        fc_reg <= 1'b1;
                        slot_out_reg <= 4'(cmp_idx_reg); exp_reg <= rd_data.expiry;
                        oc_reg <= 1'b1; os_reg <= 1'b1;
                    end
                    else if (!fa_reg && !fc_reg)
                    begin
                        fa_reg <= 1'b1;
                        slot_out_reg <= 4'(cmp_idx_reg); exp_reg <= rd_data.expiry;
                        oc_reg <= rd_data.complete; os_reg <= rd_data.seq_flag;
                    end
                end
            end
            S_LAST:
            begin
                if (op_reg == OP_ADD)
                begin
                    if (dupc_reg)
                    begin
                        status_reg <= ST_DUP_COMPLETE;
                    end
                    else if (dupp_reg)
                    begin
                        status_reg <= ST_DUP_PART;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        slot_out_reg <= 4'(fl_head); exp_reg <= wr_data.expiry;
                        oc_reg <= cmp_reg; os_reg <= hseq_reg;
                    end
                end
                else
                begin
                    status_reg <= (fa_reg || fc_reg) ? ST_OK : ST_NONE;
                end
            end
            S_RDRM:
            begin
                if (rm_commit)
                begin
                    status_reg <= ST_OK;
                    slot_out_reg <= slot_in_reg; exp_reg <= rd_data.expiry;
                    oc_reg <= rd_data.complete; os_reg <= rd_data.seq_flag;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign status = status_reg;
    assign slot_out = slot_out_reg;
    assign expire_ms = exp_reg;
    assign slot_complete = oc_reg;
    assign slot_has_seq = os_reg;

    property p_done_idle;
        @(posedge clk) disable iff (!rst_n) done_reg |-> (state_reg == S_IDLE);
    endproperty
    assert property (p_done_idle) else $error("result strobe outside idle");
    property p_one_commit;
        @(posedge clk) disable iff (!rst_n) !(add_commit && rm_commit);
    endproperty
    assert property (p_one_commit) else $error("add and remove in one cycle");
    property p_ok_fields;
        @(posedge clk) disable iff (!rst_n) (done_reg && status_reg != ST_OK) |->
            (slot_out_reg == '0 && exp_reg == '0);
    endproperty
    assert property (p_ok_fields) else $error("fields set on failed result");
    property p_add_free;
        @(posedge clk) disable iff (!rst_n) add_commit |-> !valid_reg[fl_head];
    endproperty
    assert property (p_add_free) else $error("add into occupied slot");
endmodule
`default_nettype wire
